// File: hw/rtl/periodic_task_tick_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: assertion macros
// Shared shorthand for the concurrent checks in the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Sizes, codes and record types shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  // Table geometry.
  localparam int NUM_SLOTS   = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Field widths of the stream words.
  localparam int MODE_W    = 3;
  localparam int TSLOT_W   = 3;
  localparam int PERIOD_W  = 16;
  localparam int DELAY_W   = 8;
  localparam int MASK_W    = 8;
  localparam int IN_DATA_W = 32;

  // Item kinds carried on the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_SUSPEND = 3'd3,
    MODE_RESUME  = 3'd4
  } mode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK,
    ST_DONE
  } state_t;

  // One slot record as kept in the table memory.
  typedef struct packed {
    logic [PERIOD_W-1:0]    period;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] countdown;
  } slot_entry_t;

  // Write request into the table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       entry;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// Table of periodic task slots with create, delete, suspend, resume and tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one word per item; in_tuser selects the kind
//   (tick, create, delete, suspend, resume) and in_tdata carries the slot,
//   period, start-ready flag and first delay. Only a tick produces a word on
//   the output stream: the mask of the slots that fired on it.
//   A create, delete, suspend or resume is accepted, then the slot record
//   gets one read-modify-write. Unused kinds are accepted and dropped.
//   A tick sweeps the slot table one slot per cycle through the single read
//   and write port of the table memory; the fired mask then moves into the
//   output register and becomes the result word.
//   The block holds one item at a time and raises in_tready only when idle.
//   The result sits in an output register; commands are still taken while
//   it waits, but the next tick finishes only once that register is free.
//   Reset (rst_n low, synchronous) empties the table: every slot inactive,
//   not ready, countdown zero. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_task_tick_scheduler_defines.svh"

module periodic_task_tick_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: task_slot[2:0], period_ticks[18:3], start_ready[19],
  //        first_delay[27:20], zero[31:28]
  input  wire logic [ptts_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: mode[2:0]
  input  wire logic [ptts_pkg::MODE_W-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata: fired_mask[7:0]
  output logic [ptts_pkg::MASK_W-1:0]         out_tdata
);
  import ptts_pkg::*;

  // Input word fields.
  mode_t                in_mode;
  logic [TSLOT_W-1:0]   in_slot;
  logic [PERIOD_W-1:0]  in_period;
  logic                 in_ready_flag;
  logic [DELAY_W-1:0]   in_delay;
  logic                 in_range;
  logic                 in_acc;

  // Control state.
  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    idx_r;
  logic                 out_tvalid_r;
  logic                 out_free;

  // Command and result payload.
  mode_t                cmd_mode_r;
  logic [SLOT_W-1:0]    cmd_slot_r;
  logic                 cmd_ok_r;
  logic [PERIOD_W-1:0]  cmd_period_r;
  logic                 cmd_ready_r;
  logic [DELAY_W-1:0]   cmd_delay_r;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic [MASK_W-1:0]    out_data_r;

  // Table access.
  tbl_wr_t              wr;
  logic [SLOT_W-1:0]    rd_addr;
  slot_entry_t          rd_entry;

  // Tick datapath.
  logic                   slot_active;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   slot_fire;
  logic [COUNT_WIDTH-1:0] cnt_new;

  assign in_mode       = mode_t'(in_tuser);
  assign in_slot       = in_tdata[2:0];
  assign in_period     = in_tdata[18:3];
  assign in_ready_flag = in_tdata[19];
  assign in_delay      = in_tdata[27:20];
  assign in_range      = (7'(in_slot) < 7'(NUM_SLOTS));
  assign in_acc        = in_tvalid && in_tready;
  assign out_free      = !out_tvalid_r || out_tready;

  ptts_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Per-slot tick update from the record just read.
  assign slot_active = (rd_entry.period != '0) && rd_entry.ready;
  assign cnt_dec     = rd_entry.countdown - 1'b1;
  assign slot_fire   = slot_active && (cnt_dec == '0);
  assign cnt_new     = slot_fire ? COUNT_WIDTH'(rd_entry.period) : cnt_dec;

  // Fired mask accumulation; slots beyond the mask width are not shown.
  always_comb begin
    mask_nxt = mask_r;
    for (int b = 0; b < MASK_W; b++) begin
      if (slot_fire && (32'(idx_r) == 32'(b))) begin
        mask_nxt[b] = 1'b1;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_TICK:    state_nxt = ST_TICK;
            MODE_CREATE,
            MODE_DELETE,
            MODE_SUSPEND,
            MODE_RESUME:  state_nxt = ST_CMD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CMD: begin
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic: handshake, table read address and write request.
  always_comb begin
    in_tready      = 1'b0;
    rd_addr        = '0;
    wr.en          = 1'b0;
    wr.addr        = idx_r;
    wr.entry       = rd_entry;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_mode != MODE_TICK && in_range) begin
          rd_addr = SLOT_W'(in_slot);
        end
      end
      ST_CMD: begin
        wr.en   = cmd_ok_r;
        wr.addr = cmd_slot_r;
        case (cmd_mode_r)
          MODE_CREATE: begin
            wr.entry.period    = cmd_period_r;
            wr.entry.ready     = cmd_ready_r;
            wr.entry.countdown = COUNT_WIDTH'(cmd_delay_r);
          end
          MODE_DELETE:  wr.entry.period = '0;
          MODE_SUSPEND: wr.entry.ready  = 1'b0;
          MODE_RESUME:  wr.entry.ready  = 1'b1;
          default:      wr.en           = 1'b0;
        endcase
      end
      ST_TICK: begin
        // Read the next slot while the current one is written back.
        rd_addr            = (idx_r == LAST_SLOT) ? idx_r : idx_r + 1'b1;
        wr.en              = slot_active;
        wr.addr            = idx_r;
        wr.entry.countdown = cnt_new;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        idx_r <= '0;
      end else if (state_r == ST_TICK && idx_r != LAST_SLOT) begin
        idx_r <= idx_r + 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_mode_r   <= in_mode;
      cmd_slot_r   <= SLOT_W'(in_slot);
      cmd_ok_r     <= in_range;
      cmd_period_r <= in_period;
      cmd_ready_r  <= in_ready_flag;
      cmd_delay_r  <= in_delay;
    end
    if (in_acc && in_mode == MODE_TICK) begin
      mask_r <= '0;
    end else if (state_r == ST_TICK) begin
      mask_r <= mask_nxt;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= mask_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Checks on the sequencer and the table access pattern.
  `PTTS_ASSERT_NXT(a_tick_starts_at_slot0, in_acc && in_mode == MODE_TICK, state_r == ST_TICK && idx_r == '0, "tick sweep did not start at slot zero")
  `PTTS_ASSERT_NXT(a_sweep_ends, state_r == ST_TICK && idx_r == LAST_SLOT, state_r == ST_DONE, "tick sweep did not end after the last slot")
  `PTTS_ASSERT_IMP(a_no_rw_overlap, state_r == ST_TICK && idx_r != LAST_SLOT, rd_addr != wr.addr, "tick reads the slot being written")
  `PTTS_ASSERT_IMP(a_ready_only_idle, in_tready, state_r == ST_IDLE && !wr.en, "input taken while the table is busy")

endmodule

`default_nettype wire

// File: hw/rtl/ptts_slot_table.sv
// ----------------------------------------------------------------------------
// Slot table
// One-port-write, one-port-read synchronous memory of slot records with
// per-entry valid bits, so an entry never written reads as all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_slot_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ptts_pkg::tbl_wr_t           wr,
  input  wire logic [ptts_pkg::SLOT_W-1:0] rd_addr,
  output ptts_pkg::slot_entry_t            rd_entry
);
  import ptts_pkg::*;

  slot_entry_t           mem_r [NUM_SLOTS];
  slot_entry_t           rd_data_r;
  logic [NUM_SLOTS-1:0]  valid_r;
  logic                  rd_vld_r;

  // Record storage and registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.entry;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Valid bits: reset marks every slot as holding the all-zero record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // An entry not yet written reads as the reset record.
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// File: tb/sv/periodic_task_tick_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler testbench
// Drives tick and slot command words into the scheduler and keeps its own
// copy of the slot table. Each tick's fired mask is predicted from that copy
// and checked against the word on the output stream. Both stream sides idle
// at random, and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptts_pkg::*;

  // Kinds that the block takes but ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam int PAD_W       = IN_DATA_W - TSLOT_W - PERIOD_W - 1 - DELAY_W;
  localparam int IDLE_PCT    = 11;
  localparam int RAND_ITEMS  = 1500;
  localparam int HOLD_CYCLES = 400;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [MODE_W-1:0]    in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [MASK_W-1:0]    out_tdata;

  // Shadow copy of the slot table.
  logic [PERIOD_W-1:0]    shadow_period [NUM_SLOTS];
  logic                   shadow_ready  [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] shadow_count  [NUM_SLOTS];

  // Fired masks still owed by the block, oldest first.
  logic [MASK_W-1:0] fired_mask_q [$];

  bit          idle_en       = 1'b1;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned error_count   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned cmds_sent     = 0;
  int unsigned masks_checked = 0;
  int unsigned masks_nonzero = 0;

  periodic_task_tick_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d masks still expected", fired_mask_q.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] want,
                                 input logic [MASK_W-1:0] got);
    $display("[%0t] MISMATCH %s: expected %02h, got %02h", $realtime, what, want, got);
    error_count++;
  endtask

  // One tick over the shadow table; returns the mask of slots that fired.
  function automatic logic [MASK_W-1:0] sweep_tick();
    logic [MASK_W-1:0]      fired;
    logic [COUNT_WIDTH-1:0] next;
    fired = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (shadow_period[k] != '0 && shadow_ready[k]) begin
        // A zero countdown wraps to all ones and does not fire.
        next = shadow_count[k] - 1'b1;
        if (next == '0) begin
          if (k < MASK_W) fired[k] = 1'b1;
          next = COUNT_WIDTH'(shadow_period[k]);
        end
        shadow_count[k] = next;
      end
    end
    return fired;
  endfunction

  // Update the shadow table for one accepted word.
  task automatic apply_word(input logic [MODE_W-1:0] mode_code,
                            input logic [TSLOT_W-1:0] slot,
                            input logic [PERIOD_W-1:0] period,
                            input logic ready, input logic [DELAY_W-1:0] delay);
    bit in_range;
    in_range = (int'(slot) < NUM_SLOTS);
    case (mode_code)
      MODE_TICK: begin
        fired_mask_q.push_back(sweep_tick());
        ticks_sent++;
      end
      MODE_CREATE: begin
        if (in_range) begin
          shadow_period[slot] = period;
          shadow_ready[slot]  = ready;
          shadow_count[slot]  = COUNT_WIDTH'(delay);
        end
      end
      MODE_DELETE:  if (in_range) shadow_period[slot] = '0;
      MODE_SUSPEND: if (in_range) shadow_ready[slot] = 1'b0;
      MODE_RESUME:  if (in_range) shadow_ready[slot] = 1'b1;
      default: ;
    endcase
    if (mode_code != MODE_TICK) cmds_sent++;
  endtask

  // Offer one word and wait until the block takes it.
  task automatic send_word(input logic [MODE_W-1:0] mode_code,
                           input logic [TSLOT_W-1:0] slot,
                           input logic [PERIOD_W-1:0] period,
                           input logic ready, input logic [DELAY_W-1:0] delay);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode_code;
    in_tdata  <= {{PAD_W{1'b0}}, delay, ready, period, slot};
    do @(posedge clk); while (!in_tready);
    apply_word(mode_code, slot, period, ready, delay);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (fired_mask_q.size() == 0) begin
        report_mismatch("unexpected result word", '0, out_tdata);
      end else begin
        if (out_tdata !== fired_mask_q[0])
          report_mismatch("fired_mask", fired_mask_q[0], out_tdata);
        void'(fired_mask_q.pop_front());
        masks_checked++;
        if (out_tdata != '0) masks_nonzero++;
      end
    end
  end

  // A tick on the empty table right after reset fires nothing.
  task automatic test_empty_table();
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_TICK, '1, '1, 1'b1, '1);
  endtask

  // Field extremes, every kind, wrap, suspend and resume, inactive slots.
  task automatic test_directed();
    send_word(MODE_CREATE, 3'd0, 16'd1, 1'b1, 8'd1);
    send_word(MODE_CREATE, 3'd7, 16'hFFFF, 1'b1, 8'hFF);
    // Zero first delay: the countdown wraps instead of firing.
    send_word(MODE_CREATE, 3'd3, 16'd3, 1'b1, 8'd0);
    send_word(MODE_CREATE, 3'd5, 16'd2, 1'b0, 8'd2);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_RESUME, 3'd5, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    // A suspended slot keeps its countdown across ticks.
    send_word(MODE_SUSPEND, 3'd0, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_DELETE, 3'd5, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_RESUME, 3'd0, '0, 1'b0, '0);
    // Zero period: created but inactive.
    send_word(MODE_CREATE, 3'd1, 16'd0, 1'b1, 8'd1);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_UNUSED_FIRST, 3'd0, 16'd1, 1'b1, 8'd1);
    send_word(MODE_UNUSED_LAST, 3'd6, 16'hFFFF, 1'b1, 8'hFF);
    send_word(MODE_CREATE, 3'd6, 16'd4, 1'b1, 8'd2);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
    send_word(MODE_DELETE, 3'd0, '0, 1'b0, '0);
    send_word(MODE_TICK, '0, '0, 1'b0, '0);
  endtask

  // Receiver holds off while ticks and commands keep coming.
  task automatic test_output_stall();
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 1)
        send_word(MODE_CREATE, 3'($urandom_range(7)), 16'($urandom_range(1, 4)), 1'b1,
                  8'($urandom_range(1, 4)));
      else
        send_word(MODE_TICK, '0, '0, 1'b0, '0);
    end
  endtask

  // Mostly small periods and delays so that slots fire often.
  task automatic test_random_traffic();
    int unsigned            pick;
    logic [MODE_W-1:0]      mode_code;
    logic [TSLOT_W-1:0]     slot;
    logic [PERIOD_W-1:0]    period;
    logic                   ready;
    logic [DELAY_W-1:0]     delay;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Leave a long stretch with no idling on either side.
      idle_en = !(i >= 600 && i < 800);
      pick   = $urandom_range(99);
      slot   = 3'($urandom_range(7));
      period = 16'($urandom);
      ready  = 1'($urandom);
      delay  = 8'($urandom);
      if (pick < 55) begin
        mode_code = MODE_TICK;
      end else if (pick < 75) begin
        mode_code = MODE_CREATE;
        pick = $urandom_range(99);
        if (pick < 80) period = 16'($urandom_range(1, 12));
        else if (pick < 90) period = '0;
        if ($urandom_range(99) < 85) delay = 8'($urandom_range(12));
        ready = ($urandom_range(99) < 75);
      end else if (pick < 83) begin
        mode_code = MODE_DELETE;
      end else if (pick < 90) begin
        mode_code = MODE_SUSPEND;
      end else if (pick < 97) begin
        mode_code = MODE_RESUME;
      end else begin
        mode_code = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      end
      send_word(mode_code, slot, period, ready, delay);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      shadow_period[k] = '0;
      shadow_ready[k]  = 1'b0;
      shadow_count[k]  = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed();
    test_output_stall();
    test_random_traffic();
    in_tvalid <= 1'b0;

    // Drain the outstanding masks, then give the block time to misbehave.
    while (fired_mask_q.size() != 0) @(posedge clk);
    repeat (4 * (NUM_SLOTS + 2)) @(posedge clk);

    $display("Covered %0d ticks and %0d slot commands; %0d masks checked, %0d non-empty.",
             ticks_sent, cmds_sent, masks_checked, masks_nonzero);
    $display("Included suspend, resume, delete, zero-countdown wrap and a long output stall.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
